// ===== hdl/nrp_pkg.sv =====
// Shared types, codes and constants of the nested region profiler.
package nrp_pkg;

    // Default sizes of the anchor table and of the nesting stack.
    localparam int ANCHOR_COUNT_DEF = 4096;
    localparam int NEST_DEPTH_DEF   = 32;

    // Field widths of the transactions.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

    // One row of the counter table.
    typedef struct packed {
        logic [TIME_W-1:0] hits;
        logic [TIME_W-1:0] inclusive;
        logic [TIME_W-1:0] exclusive;
    } t_counters;

    localparam int CTR_W = $bits(t_counters);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_DISPATCH,
        ST_ENTER,
        ST_READ,
        ST_POP,
        ST_PARENT,
        ST_ANCHOR_RD,
        ST_ANCHOR,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/nrp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module nrp_ram
    import nrp_pkg::*;
#(
    parameter int WIDTH = CTR_W,
    parameter int DEPTH = ANCHOR_COUNT_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/nrp_slot.sv =====
// Two-stage reduction of a raw anchor index modulo the anchor count.
module nrp_slot
    import nrp_pkg::*;
#(
    parameter int ANCHOR_COUNT = ANCHOR_COUNT_DEF,
    localparam int IDX_W = $clog2(ANCHOR_COUNT)
) (
    input  logic               i_clk,
    input  logic [INDEX_W-1:0] i_raw,
    output logic [IDX_W-1:0]   o_slot
);

    // Reciprocal rounded up; with a 32-bit scale the quotient of a 12-bit value is exact.
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + 64'(ANCHOR_COUNT) - 64'd1) / 64'(ANCHOR_COUNT);
    localparam logic [31:0] RECIP = 32'(RECIP_L);
    localparam int PROD_W = INDEX_W + 32;
    localparam int REM_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    logic [PROD_W-1:0]  w_prod;
    logic [REM_W-1:0]   w_rem;
    logic [INDEX_W-1:0] r_raw;
    logic [INDEX_W-1:0] r_quot;
    logic [IDX_W-1:0]   r_slot;

    // First stage: quotient by multiplication with the reciprocal.
    assign w_prod = PROD_W'(i_raw) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        r_raw  <= i_raw;
        r_quot <= w_prod[PROD_W-1:32];
    end

    // Second stage: remainder from the exact quotient.
    assign w_rem = REM_W'(r_raw) - REM_W'(REM_W'(r_quot) * REM_W'(ANCHOR_COUNT));

    always_ff @(posedge i_clk) begin
        r_slot <= w_rem[IDX_W-1:0];
    end

    assign o_slot = r_slot;

endmodule

// ===== hdl/nested_region_profiler_unit.sv =====
// Top level of the nested region profiler: sequencer over the counter and stack memories.
//
// The profiler keeps an exclusive time, an inclusive time and a hit count for each
// of ANCHOR_COUNT anchors in one table memory, and the open regions on a stack
// memory of NEST_DEPTH frames. After reset the block sweeps the counter table to
// zero, one row per cycle; input is stalled until the sweep ends. One transaction
// is handled at a time. An exit takes the longest, as the counter table has a
// single read and write port: an exit reads and rewrites the parent row, then the
// anchor row. The result is loaded into the output register as the block returns
// to idle. The result waits in an output register, so the next transaction is
// accepted while it is still stalled, and only the following result waits for it
// to be taken.
module nested_region_profiler_unit
    import nrp_pkg::*;
#(
    parameter int ANCHOR_COUNT = ANCHOR_COUNT_DEF,
    parameter int NEST_DEPTH   = NEST_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [INDEX_W-1:0]  i_anchor_index,
    input  logic [TIME_W-1:0]   i_timestamp,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_exclusive_time,
    output logic [TIME_W-1:0]   o_inclusive_time,
    output logic [TIME_W-1:0]   o_hit_count
);

    localparam int IDX_W   = $clog2(ANCHOR_COUNT);
    localparam int SA_W    = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int LVL_W   = $clog2(NEST_DEPTH + 1);
    localparam int FRAME_W = 2 * IDX_W + 2 * TIME_W;

    // Frame layout on the stack: parent, anchor, inclusive snapshot, start time.
    localparam int F_START_LO = 0;
    localparam int F_INC_LO   = TIME_W;
    localparam int F_ANC_LO   = 2 * TIME_W;
    localparam int F_PAR_LO   = 2 * TIME_W + IDX_W;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ANCHOR_COUNT - 1);
    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(NEST_DEPTH);

    // Control registers.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_addr, n_clr_addr;
    logic [LVL_W-1:0]   r_level, n_level;
    logic [IDX_W-1:0]   r_parent, n_parent;
    logic               r_out_valid, n_out_valid;

    // Transaction registers.
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [IDX_W-1:0]    r_anchor, n_anchor;
    logic [IDX_W-1:0]    r_pop_par, n_pop_par;
    logic [IDX_W-1:0]    r_pop_anc, n_pop_anc;
    logic [TIME_W-1:0]   r_old_inc, n_old_inc;
    logic [TIME_W-1:0]   r_elapsed, n_elapsed;
    logic [STATUS_W-1:0] r_status, n_status;
    t_counters           r_res, n_res;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    t_counters           r_out_res, n_out_res;

    // Memory ports.
    logic               w_tbl_we;
    logic [IDX_W-1:0]   w_tbl_waddr;
    t_counters          w_tbl_wdata;
    logic [IDX_W-1:0]   w_tbl_raddr;
    logic [CTR_W-1:0]   w_tbl_rdata;
    t_counters          w_tbl_rd;
    logic               w_stk_we;
    logic [SA_W-1:0]    w_stk_waddr;
    logic [FRAME_W-1:0] w_stk_wdata;
    logic [SA_W-1:0]    w_stk_raddr;
    logic [FRAME_W-1:0] w_stk_rdata;
    logic [LVL_W-1:0]   w_level_dec;

    logic [IDX_W-1:0]   w_slot;

    // Anchor index reduction; its result is read in the dispatch state.
    nrp_slot #(
        .ANCHOR_COUNT(ANCHOR_COUNT)
    ) u_slot (
        .i_clk  (i_clk),
        .i_raw  (i_anchor_index),
        .o_slot (w_slot)
    );

    // Counter table: one row per anchor.
    nrp_ram #(
        .WIDTH(CTR_W),
        .DEPTH(ANCHOR_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    // Nesting stack: one frame per open region.
    nrp_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(NEST_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    assign w_tbl_rd    = t_counters'(w_tbl_rdata);
    assign w_level_dec = r_level - LVL_W'(1);

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_level     <= '0;
            r_parent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_level     <= n_level;
            r_parent    <= n_parent;
            r_out_valid <= n_out_valid;
        end
    end

    // Transaction and result registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_time       <= n_time;
        r_anchor     <= n_anchor;
        r_pop_par    <= n_pop_par;
        r_pop_anc    <= n_pop_anc;
        r_old_inc    <= n_old_inc;
        r_elapsed    <= n_elapsed;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_res    <= n_out_res;
    end

    // Next state, memory accesses and register updates.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_level      = r_level;
        n_parent     = r_parent;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_time       = r_time;
        n_anchor     = r_anchor;
        n_pop_par    = r_pop_par;
        n_pop_anc    = r_pop_anc;
        n_old_inc    = r_old_inc;
        n_elapsed    = r_elapsed;
        n_status     = r_status;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_res    = r_out_res;

        w_tbl_we    = 1'b0;
        w_tbl_waddr = r_pop_anc;
        w_tbl_wdata = '0;
        w_tbl_raddr = r_pop_anc;
        w_stk_we    = 1'b0;
        w_stk_waddr = r_level[SA_W-1:0];
        w_stk_wdata = {r_parent, r_anchor, w_tbl_rd.inclusive, r_time};
        w_stk_raddr = w_level_dec[SA_W-1:0];

        // The output register empties when its transaction is taken.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Sweep the counter table to zero after reset.
            ST_CLEAR: begin
                w_tbl_we    = 1'b1;
                w_tbl_waddr = r_clr_addr;
                w_tbl_wdata = '0;
                n_clr_addr  = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_time  = i_timestamp;
                    n_state = ST_SLOT;
                end
            end

            // The index reduction is in flight.
            ST_SLOT: begin
                n_state = ST_DISPATCH;
            end

            // Check the stack and start the first memory read of the command.
            ST_DISPATCH: begin
                n_anchor = w_slot;
                n_status = STS_OK;
                n_res    = '0;
                n_state  = ST_DONE;
                case (r_cmd)
                    CMD_ENTER: begin
                        if (r_level == FULL_LVL) begin
                            n_status = STS_OVERFLOW;
                        end else begin
                            w_tbl_raddr = w_slot;
                            n_state     = ST_ENTER;
                        end
                    end
                    CMD_EXIT: begin
                        if (r_level == '0) begin
                            n_status = STS_UNDERFLOW;
                        end else begin
                            n_state = ST_POP;
                        end
                    end
                    CMD_READ: begin
                        w_tbl_raddr = w_slot;
                        n_state     = ST_READ;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            // Push a frame with the anchor's inclusive snapshot.
            ST_ENTER: begin
                w_stk_we = 1'b1;
                n_level  = r_level + LVL_W'(1);
                n_parent = r_anchor;
                n_state  = ST_DONE;
            end

            ST_READ: begin
                n_res   = w_tbl_rd;
                n_state = ST_DONE;
            end

            // Pop the frame, compute the elapsed time and read the parent row.
            ST_POP: begin
                n_pop_par   = w_stk_rdata[F_PAR_LO +: IDX_W];
                n_pop_anc   = w_stk_rdata[F_ANC_LO +: IDX_W];
                n_old_inc   = w_stk_rdata[F_INC_LO +: TIME_W];
                n_elapsed   = r_time - w_stk_rdata[F_START_LO +: TIME_W];
                w_tbl_raddr = w_stk_rdata[F_PAR_LO +: IDX_W];
                n_level     = w_level_dec;
                n_parent    = w_stk_rdata[F_PAR_LO +: IDX_W];
                n_state     = ST_PARENT;
            end

            // Charge the elapsed time against the parent's exclusive total.
            ST_PARENT: begin
                w_tbl_we              = 1'b1;
                w_tbl_waddr           = r_pop_par;
                w_tbl_wdata           = w_tbl_rd;
                w_tbl_wdata.exclusive = w_tbl_rd.exclusive - r_elapsed;
                n_state               = ST_ANCHOR_RD;
            end

            // Read the anchor row after the parent row has been written.
            ST_ANCHOR_RD: begin
                w_tbl_raddr = r_pop_anc;
                n_state     = ST_ANCHOR;
            end

            ST_ANCHOR: begin
                w_tbl_we              = 1'b1;
                w_tbl_waddr           = r_pop_anc;
                w_tbl_wdata.exclusive = w_tbl_rd.exclusive + r_elapsed;
                w_tbl_wdata.inclusive = r_old_inc + r_elapsed;
                w_tbl_wdata.hits      = w_tbl_rd.hits + TIME_W'(1);
                n_state               = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_res    = r_res;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_exclusive_time = r_out_res.exclusive;
    assign o_inclusive_time = r_out_res.inclusive;
    assign o_hit_count      = r_out_res.hits;

endmodule
